### rtl/core/pfb_pkg.sv
// ----------------------------------------------------------------------------
// pfb_pkg: shared types and constants for the palette fade blend
// Widths, register map codes, pipeline depth and the derived-config struct.
// ----------------------------------------------------------------------------
package pfb_pkg;

    localparam int COMP_W     = 8;    // one color component
    localparam int NUM_LANES  = 3;    // red, green, blue
    localparam int DATA_W     = COMP_W * NUM_LANES;
    localparam int FADE_W     = 16;   // fade step / span
    localparam int NUM_W      = COMP_W + FADE_W;  // blend numerator
    localparam int QUOT_W     = COMP_W;           // one quotient bit per divide stage
    localparam int APB_AW     = 5;
    localparam int APB_DW     = 32;
    localparam int REG_IDX_W  = 3;

    // lane stages: source, multiply, sum, then one per quotient bit
    localparam int DIV_STAGE0  = 3;
    localparam int LANE_STAGES = DIV_STAGE0 + QUOT_W;
    // plus the output (merge) register
    localparam int PIPE_DEPTH  = LANE_STAGES + 1;

    localparam logic [REG_IDX_W-1:0] REG_FADE_STEP    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_FADE_SPAN    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_TARGET_RED   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_TARGET_GREEN = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_TARGET_BLUE  = 3'd4;

    localparam logic [FADE_W-1:0] FADE_STEP_RST = 16'd0;
    localparam logic [FADE_W-1:0] FADE_SPAN_RST = 16'd1;
    localparam logic [COMP_W-1:0] TARGET_RST    = 8'd0;

    // blend coefficients, settled from the registers
    typedef struct packed {
        logic [FADE_W-1:0] step;     // clamped step, weight of target
        logic [FADE_W-1:0] comp;     // span - step, weight of source
        logic [FADE_W-1:0] div;      // span, never zero
        logic [FADE_W-2:0] half;     // span / 2 for rounding
        logic [COMP_W-1:0] tgt_red;
        logic [COMP_W-1:0] tgt_green;
        logic [COMP_W-1:0] tgt_blue;
    } t_cfg;

    typedef struct packed {
        logic [PIPE_DEPTH-1:0] en;        // stage load enables
        logic                  out_valid; // merge register holds a result
    } t_pipe_ctl;

endpackage

### rtl/core/palette_fade_blend.sv
// ----------------------------------------------------------------------------
// palette_fade_blend: palette entry fade toward a target color
// Input stream s_*: one palette entry per transfer, s_tdata = {blue, green, red}.
// Output stream m_*: one blended entry per input, in order, same packing.
// Each component is (src*(span-step) + target*step + span/2) / span with the
// step clamped to the span and a zero span taken as one.
// Throughput: one entry per cycle, sustained while m_tready stays high; 12
// registers (source, multiply, sum, 8 divide stages, output) lie between input
// transfer and m_tvalid, and the first of them loads at the input transfer.
// The divide is restoring, one quotient bit per stage in each of three
// component lanes; the output register merges the lanes.
// When m_tready is low, entries back up stage by stage and s_tready drops only
// once every stage is full; empty stages keep taking entries meanwhile.
// Registers on the APB port: fade_step 0x00, fade_span 0x04, target red/green/
// blue 0x08/0x0C/0x10. Write them only while no entries are in flight.
// Reset (synchronous, active low) empties the pipeline and sets step 0,
// span 1 and a black target.
// ----------------------------------------------------------------------------
module palette_fade_blend (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // [7:0] src_red, [15:8] src_green, [23:16] src_blue
    input  logic [pfb_pkg::DATA_W-1:0] s_tdata,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // [7:0] out_red, [15:8] out_green, [23:16] out_blue
    output logic [pfb_pkg::DATA_W-1:0] m_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [pfb_pkg::APB_AW-1:0] paddr,
    input  logic [pfb_pkg::APB_DW-1:0] pwdata,
    output logic [pfb_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    import pfb_pkg::*;

    t_cfg              cfg;
    t_pipe_ctl         ctl;
    logic [COMP_W-1:0] tgt  [NUM_LANES];
    logic [QUOT_W-1:0] quot [NUM_LANES];
    logic [DATA_W-1:0] r_out_data;

    pfb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    pfb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_tvalid),
        .i_out_ready (m_tready),
        .o_ctl       (ctl)
    );

    assign tgt[0] = cfg.tgt_red;
    assign tgt[1] = cfg.tgt_green;
    assign tgt[2] = cfg.tgt_blue;

    for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
        pfb_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (ctl.en[LANE_STAGES-1:0]),
            .i_src  (s_tdata[l*COMP_W +: COMP_W]),
            .i_tgt  (tgt[l]),
            .i_cfg  (cfg),
            .o_quot (quot[l])
        );
    end

    // merge the lane results into one output word
    always_ff @(posedge i_clk) begin
        if (ctl.en[PIPE_DEPTH-1]) begin
            for (int l = 0; l < NUM_LANES; l++) begin
                r_out_data[l*COMP_W +: COMP_W] <= quot[l];
            end
        end
    end

    assign s_tready = ctl.en[0];
    assign m_tvalid = ctl.out_valid;
    assign m_tdata  = r_out_data;

endmodule

### rtl/core/pfb_regs.sv
// ----------------------------------------------------------------------------
// pfb_regs: configuration registers
// APB-style register file plus the registered blend coefficients.
// ----------------------------------------------------------------------------
module pfb_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [pfb_pkg::APB_AW-1:0] paddr,
    input  logic [pfb_pkg::APB_DW-1:0] pwdata,
    output logic [pfb_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    output pfb_pkg::t_cfg              o_cfg
);
    import pfb_pkg::*;

    logic [FADE_W-1:0]    r_fade_step;
    logic [FADE_W-1:0]    r_fade_span;
    logic [COMP_W-1:0]    r_tgt_red;
    logic [COMP_W-1:0]    r_tgt_green;
    logic [COMP_W-1:0]    r_tgt_blue;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;
    logic [FADE_W-1:0]    span_eff;
    logic [FADE_W-1:0]    step_clamp;
    t_cfg                 n_cfg;
    t_cfg                 r_cfg;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_AW-1:2];
    assign wr_en   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fade_step <= FADE_STEP_RST;
            r_fade_span <= FADE_SPAN_RST;
            r_tgt_red   <= TARGET_RST;
            r_tgt_green <= TARGET_RST;
            r_tgt_blue  <= TARGET_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_FADE_STEP:    r_fade_step <= pwdata[FADE_W-1:0];
                REG_FADE_SPAN:    r_fade_span <= pwdata[FADE_W-1:0];
                REG_TARGET_RED:   r_tgt_red   <= pwdata[COMP_W-1:0];
                REG_TARGET_GREEN: r_tgt_green <= pwdata[COMP_W-1:0];
                REG_TARGET_BLUE:  r_tgt_blue  <= pwdata[COMP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_FADE_STEP:    prdata = APB_DW'(r_fade_step);
            REG_FADE_SPAN:    prdata = APB_DW'(r_fade_span);
            REG_TARGET_RED:   prdata = APB_DW'(r_tgt_red);
            REG_TARGET_GREEN: prdata = APB_DW'(r_tgt_green);
            REG_TARGET_BLUE:  prdata = APB_DW'(r_tgt_blue);
            default:          prdata = '0;
        endcase
    end

    // zero span acts as one; step beyond span clamps to span
    always_comb begin
        span_eff   = (r_fade_span == '0) ? FADE_W'(1) : r_fade_span;
        step_clamp = (r_fade_step > span_eff) ? span_eff : r_fade_step;
        n_cfg.step      = step_clamp;
        n_cfg.comp      = span_eff - step_clamp;
        n_cfg.div       = span_eff;
        n_cfg.half      = span_eff[FADE_W-1:1];
        n_cfg.tgt_red   = r_tgt_red;
        n_cfg.tgt_green = r_tgt_green;
        n_cfg.tgt_blue  = r_tgt_blue;
    end

    // registered copy of the coefficients; first used at the multiply stage
    always_ff @(posedge i_clk) begin
        r_cfg <= n_cfg;
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/core/pfb_lane.sv
// ----------------------------------------------------------------------------
// pfb_lane: one color component of the blend
// Weighted sum with rounding term, then a restoring divide, one quotient bit
// per stage.
// ----------------------------------------------------------------------------
module pfb_lane (
    input  logic                                 i_clk,
    input  logic [pfb_pkg::LANE_STAGES-1:0]      i_en,
    input  logic [pfb_pkg::COMP_W-1:0]           i_src,
    input  logic [pfb_pkg::COMP_W-1:0]           i_tgt,
    input  pfb_pkg::t_cfg                        i_cfg,
    output logic [pfb_pkg::QUOT_W-1:0]           o_quot
);
    import pfb_pkg::*;

    logic [COMP_W-1:0] r_src;
    logic [NUM_W-1:0]  r_prod_src;
    logic [NUM_W-1:0]  r_prod_tgt;
    logic [NUM_W-1:0]  r_num;
    logic [NUM_W-1:0]  r_rem  [QUOT_W-1];
    logic [QUOT_W-1:0] r_quot [QUOT_W];

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_src <= i_src;
        end
        if (i_en[1]) begin
            r_prod_src <= NUM_W'(r_src) * NUM_W'(i_cfg.comp);
            r_prod_tgt <= NUM_W'(i_tgt) * NUM_W'(i_cfg.step);
        end
        if (i_en[2]) begin
            r_num <= r_prod_src + r_prod_tgt + NUM_W'(i_cfg.half);
        end
    end

    // quotient fits in QUOT_W bits since the blend stays within a component
    for (genvar d = 0; d < QUOT_W; d++) begin : g_div
        logic [NUM_W-1:0]  rem_in;
        logic [QUOT_W-1:0] quot_in;
        logic [NUM_W-1:0]  dvsr;
        logic              fits;

        if (d == 0) begin : g_first
            assign rem_in  = r_num;
            assign quot_in = '0;
        end else begin : g_next
            assign rem_in  = r_rem[d-1];
            assign quot_in = r_quot[d-1];
        end

        assign dvsr = NUM_W'(i_cfg.div) << (QUOT_W - 1 - d);
        assign fits = (rem_in >= dvsr);

        always_ff @(posedge i_clk) begin
            if (i_en[DIV_STAGE0+d]) begin
                r_quot[d] <= quot_in | (QUOT_W'(fits) << (QUOT_W - 1 - d));
            end
        end

        // last stage keeps no remainder
        if (d < QUOT_W - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en[DIV_STAGE0+d]) begin
                    r_rem[d] <= fits ? (rem_in - dvsr) : rem_in;
                end
            end
        end
    end

    assign o_quot = r_quot[QUOT_W-1];

endmodule

### rtl/core/pfb_ctrl.sv
// ----------------------------------------------------------------------------
// pfb_ctrl: pipeline flow control
// Per-stage valid bits; a stage loads when it is empty or its data moves on,
// so bubbles collapse and stalls back up one stage at a time.
// ----------------------------------------------------------------------------
module pfb_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_out_ready,
    output pfb_pkg::t_pipe_ctl o_ctl
);
    import pfb_pkg::*;

    logic [PIPE_DEPTH-1:0] r_valid;
    logic [PIPE_DEPTH-1:0] n_valid;
    logic [PIPE_DEPTH-1:0] en;

    always_comb begin
        en[PIPE_DEPTH-1] = ~r_valid[PIPE_DEPTH-1] | i_out_ready;
        for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
            en[k] = ~r_valid[k] | en[k+1];
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (en[0]) begin
            n_valid[0] = i_in_valid;
        end
        for (int k = 1; k < PIPE_DEPTH; k++) begin
            if (en[k]) begin
                n_valid[k] = r_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_ctl.en        = en;
    assign o_ctl.out_valid = r_valid[PIPE_DEPTH-1];

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for palette_fade_blend
// Streams palette entries through the blend pipeline under several fade
// settings and checks every blended entry against an in-bench blend model.
// Both stream sides idle at random, and the sink holds off for one long stretch.
// ----------------------------------------------------------------------------
module tb;
    import pfb_pkg::*;

    typedef struct packed {
        logic [COMP_W-1:0] blue;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] red;
    } t_rgb;

    localparam logic [REG_IDX_W-1:0] REG_FIRST_UNUSED = 3'd5;
    localparam int REG_SLOTS = 2 ** REG_IDX_W;
    localparam int HOLD_CYCLES = 60;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic [DATA_W-1:0] s_tdata = '0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] m_tdata;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    palette_fade_blend dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_tdata (s_tdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tdata (m_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // local copy of the fade registers
    logic [FADE_W-1:0] fade_step_q = FADE_STEP_RST;
    logic [FADE_W-1:0] fade_span_q = FADE_SPAN_RST;
    t_rgb              target_q    = '0;

    t_rgb entries_to_send[$];
    t_rgb blends_due[$];
    int   mismatches = 0;
    int   src_idle_pct = 13;
    int   snk_idle_pct = 13;
    int   hold_start = 0;
    int   hold_seen = 0;
    int   hold_left = 0;
    logic s_took = 1'b0;

    function automatic logic [COMP_W-1:0] blend_lane(logic [COMP_W-1:0] src,
                                                     logic [COMP_W-1:0] tgt);
        logic [31:0] span;
        logic [31:0] step;
        logic [31:0] acc;
        span = (fade_span_q == 0) ? 32'd1 : 32'(fade_span_q);
        step = (32'(fade_step_q) > span) ? span : 32'(fade_step_q);
        acc  = 32'(src) * (span - step) + 32'(tgt) * step + (span >> 1);
        return COMP_W'(acc / span);
    endfunction

    function automatic t_rgb fade_entry(t_rgb src);
        t_rgb res;
        res.red   = blend_lane(src.red, target_q.red);
        res.green = blend_lane(src.green, target_q.green);
        res.blue  = blend_lane(src.blue, target_q.blue);
        return res;
    endfunction

    // source side
    always @(negedge i_clk) begin
        if (i_rst_n && (!s_tvalid || s_took)) begin
            if (entries_to_send.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                s_tdata  <= entries_to_send.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // sink side, with the long hold-off counted here
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else if (hold_start != hold_seen) begin
            hold_seen = hold_start;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_rgb got;
        t_rgb want;
        s_took <= s_tvalid && s_tready;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = m_tdata;
            if (blends_due.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected entry %06h, none pending", $time, got);
            end else begin
                want = blends_due.pop_front();
                if (got.red !== want.red) begin
                    mismatches++;
                    $display("%0t: red expected %02h actual %02h", $time, want.red, got.red);
                end
                if (got.green !== want.green) begin
                    mismatches++;
                    $display("%0t: green expected %02h actual %02h", $time,
                             want.green, got.green);
                end
                if (got.blue !== want.blue) begin
                    mismatches++;
                    $display("%0t: blue expected %02h actual %02h", $time,
                             want.blue, got.blue);
                end
            end
        end
        if (i_rst_n && s_tvalid && s_tready)
            blends_due.push_back(fade_entry(t_rgb'(s_tdata)));
    end

    task automatic reg_write(logic [REG_IDX_W-1:0] idx, logic [APB_DW-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_FADE_STEP:    fade_step_q = value[FADE_W-1:0];
            REG_FADE_SPAN:    fade_span_q = value[FADE_W-1:0];
            REG_TARGET_RED:   target_q.red = value[COMP_W-1:0];
            REG_TARGET_GREEN: target_q.green = value[COMP_W-1:0];
            REG_TARGET_BLUE:  target_q.blue = value[COMP_W-1:0];
            default: ; // unmapped, ignored
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_fade(int step, int span, int r, int g, int b);
        reg_write(REG_FADE_STEP, APB_DW'(step));
        reg_write(REG_FADE_SPAN, APB_DW'(span));
        reg_write(REG_TARGET_RED, APB_DW'(r));
        reg_write(REG_TARGET_GREEN, APB_DW'(g));
        reg_write(REG_TARGET_BLUE, APB_DW'(b));
    endtask

    task automatic push_entry(int r, int g, int b);
        t_rgb e;
        e.red   = COMP_W'(r);
        e.green = COMP_W'(g);
        e.blue  = COMP_W'(b);
        entries_to_send.push_back(e);
    endtask

    task automatic drain();
        while (entries_to_send.size() != 0 || s_tvalid || blends_due.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_DEPTH + 2) @(posedge i_clk);
    endtask

    function automatic int rand_comp();
        case ($urandom_range(7))
            0: return 0;
            1: return 255;
            default: return $urandom_range(255);
        endcase
    endfunction

    task automatic push_random(int n);
        for (int k = 0; k < n; k++)
            push_entry(rand_comp(), rand_comp(), rand_comp());
    endtask

    initial begin
        int span;
        int step;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings pass the source through unchanged
        push_entry(0, 0, 0);
        push_entry(255, 255, 255);
        push_entry(255, 0, 0);
        push_entry(0, 255, 0);
        push_entry(0, 0, 255);
        push_entry(8'ha5, 8'h5a, 8'hc3);
        drain();

        // full fade at the widest span lands on the target
        set_fade(65535, 65535, 255, 0, 128);
        push_entry(0, 255, 17);
        push_entry(255, 0, 200);
        push_entry(8'h5a, 8'ha5, 8'h3c);
        drain();

        // step beyond span clamps to the target
        set_fade(40000, 7, 12, 250, 99);
        push_entry(0, 0, 0);
        push_entry(255, 255, 255);
        drain();

        // zero span acts as one
        set_fade(0, 0, 1, 2, 3);
        push_entry(200, 100, 50);
        drain();
        reg_write(REG_FADE_STEP, 5);
        push_entry(200, 100, 50);
        drain();

        // exact halves round up
        set_fade(3, 6, 1, 255, 0);
        push_entry(0, 0, 255);
        push_entry(255, 254, 1);
        push_entry(1, 0, 0);
        drain();

        // unmapped registers leave the settings alone
        set_fade(1, 65535, 255, 255, 255);
        for (int k = REG_FIRST_UNUSED; k < REG_SLOTS; k++)
            reg_write(REG_IDX_W'(k), $urandom());
        push_entry(0, 128, 255);
        push_entry(255, 255, 0);
        drain();

        for (int ph = 0; ph < 16; ph++) begin
            case ($urandom_range(3))
                0: span = $urandom_range(1, 16);
                1: span = $urandom_range(1, 300);
                2: span = $urandom_range(0, 65535);
                default: span = ($urandom_range(1) == 0) ? 65535 : $urandom_range(0, 1);
            endcase
            case ($urandom_range(3))
                0: step = $urandom_range(0, 65535);
                1: step = 0;
                default: step = $urandom_range(0, span + span / 4 + 1);
            endcase
            set_fade(step, span, rand_comp(), rand_comp(), rand_comp());
            if ($urandom_range(3) == 0)
                reg_write(REG_IDX_W'($urandom_range(REG_FIRST_UNUSED, REG_SLOTS - 1)),
                          $urandom());

            src_idle_pct = 13;
            snk_idle_pct = 13;
            if (ph == 4) begin
                // long stretch at full rate on both sides
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            push_random(100);
            if (ph == 7) begin
                // sink stalls while the source keeps offering; pipeline fills
                src_idle_pct = 0;
                hold_start++;
            end
            drain();
        end

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("Mismatches found");
        $finish;
    end

endmodule

### files.f
rtl/core/pfb_pkg.sv
rtl/core/pfb_regs.sv
rtl/core/pfb_lane.sv
rtl/core/pfb_ctrl.sv
rtl/core/palette_fade_blend.sv
bench/tb.sv
